### src/led_matrix_row_scanner_top_defines.svh
// assertion macros for the led matrix row scanner
// expects aclk and aresetn in the scope of each use
`ifndef LED_MATRIX_ROW_SCANNER_TOP_DEFINES_SVH
`define LED_MATRIX_ROW_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LMRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LMRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lmrs_pkg.sv
// package for the led matrix row scanner: widths, codes, command and status structs
// and the cell code to color mapping; no dependencies
`default_nettype none

package lmrs_pkg;

    localparam int PANEL_COLUMNS_DEF = 64;
    localparam int PANEL_ROWS_DEF    = 32;

    localparam int ROW_IN_W   = 5;
    localparam int COL_IN_W   = 6;
    localparam int CODE_W     = 8;
    localparam int COL_OUT_W  = 6;
    localparam int RGB_W      = 3;
    localparam int ADDR_OUT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCAN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WALL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY = 2'd2;

    localparam logic [CODE_W-1:0] WALL_CODE_RST = 8'd35;
    localparam logic [CODE_W-1:0] BEAK_CODE_RST = 8'd62;
    localparam logic [CODE_W-1:0] BODY_CODE_RST = 8'd110;

    localparam logic [RGB_W-1:0] RGB_BLACK  = 3'b000;
    localparam logic [RGB_W-1:0] RGB_RED    = 3'b001;
    localparam logic [RGB_W-1:0] RGB_GREEN  = 3'b010;
    localparam logic [RGB_W-1:0] RGB_YELLOW = 3'b011;

    typedef struct packed {
        logic clear_en;
        logic cell_write;
        logic scan_start;
        logic issue;
        logic row_advance;
    } lmrs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic col_last;
        logic issue_ok;
        logic pipe_empty;
    } lmrs_sts_t;

    // first match wins: wall, beak, body
    function automatic logic [RGB_W-1:0] code_to_rgb(
        input logic [CODE_W-1:0] code,
        input logic [CODE_W-1:0] wall,
        input logic [CODE_W-1:0] beak,
        input logic [CODE_W-1:0] body
    );
        logic [RGB_W-1:0] rgb;
        if (code == wall) begin
            rgb = RGB_GREEN;
        end else if (code == beak) begin
            rgb = RGB_RED;
        end else if (code == body) begin
            rgb = RGB_YELLOW;
        end else begin
            rgb = RGB_BLACK;
        end
        return rgb;
    endfunction

endpackage

`default_nettype wire

### src/lmrs_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/lmrs_ctrl.sv
// controller for the led matrix row scanner: clear sweep, item intake, scan sequencing
// depends on lmrs_pkg
`default_nettype none

module lmrs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid_i,
    input  wire logic                s_action_i,
    output      logic                s_ready_o,
    input  wire lmrs_pkg::lmrs_sts_t sts_i,
    output      lmrs_pkg::lmrs_cmd_t cmd_o
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic accept;

    assign s_ready_o = (state_reg == ST_IDLE);
    assign accept    = s_valid_i && s_ready_o;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd_o.clear_en = 1'b1;
                if (sts_i.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_action_i == lmrs_pkg::ACT_SCAN) begin
                        cmd_o.scan_start = 1'b1;
                        state_next       = ST_SCAN;
                    end else begin
                        cmd_o.cell_write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (sts_i.issue_ok) begin
                    cmd_o.issue = 1'b1;
                    if (sts_i.col_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (sts_i.pipe_empty) begin
                    cmd_o.row_advance = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/lmrs_datapath.sv
// datapath for the led matrix row scanner: frame store, counters, color registers,
// read pipeline and output register; depends on lmrs_pkg, lmrs_ram and the defines header
`default_nettype none

`include "led_matrix_row_scanner_top_defines.svh"

module lmrs_datapath #(
    parameter int PANEL_COLUMNS = lmrs_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = lmrs_pkg::PANEL_ROWS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire lmrs_pkg::lmrs_cmd_t               cmd_i,
    output      lmrs_pkg::lmrs_sts_t               sts_o,
    input  wire logic [lmrs_pkg::ROW_IN_W-1:0]     cell_row_i,
    input  wire logic [lmrs_pkg::COL_IN_W-1:0]     cell_col_i,
    input  wire logic [lmrs_pkg::CODE_W-1:0]       cell_code_i,
    input  wire logic                              cfg_we_i,
    input  wire logic [lmrs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
    input  wire logic [lmrs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
    input  wire logic                              m_ready_i,
    output      logic                              m_valid_o,
    output      logic [lmrs_pkg::COL_OUT_W-1:0]    m_column_o,
    output      logic [lmrs_pkg::RGB_W-1:0]        m_top_rgb_o,
    output      logic [lmrs_pkg::RGB_W-1:0]        m_bottom_rgb_o,
    output      logic [lmrs_pkg::ADDR_OUT_W-1:0]   m_row_address_o,
    output      logic                              m_latch_last_o
);

    localparam int CW    = $clog2(PANEL_COLUMNS);
    localparam int RW    = $clog2(PANEL_ROWS);
    localparam int CELLS = PANEL_ROWS * PANEL_COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int HALF  = PANEL_ROWS / 2;

    // color code registers
    logic [lmrs_pkg::CODE_W-1:0] wall_code_reg, wall_code_next;
    logic [lmrs_pkg::CODE_W-1:0] beak_code_reg, beak_code_next;
    logic [lmrs_pkg::CODE_W-1:0] body_code_reg, body_code_next;

    always_comb begin
        wall_code_next = wall_code_reg;
        beak_code_next = beak_code_reg;
        body_code_next = body_code_reg;
        if (cfg_we_i) begin
            unique case (cfg_index_i)
                lmrs_pkg::CFG_WALL: wall_code_next = cfg_data_i;
                lmrs_pkg::CFG_BEAK: beak_code_next = cfg_data_i;
                lmrs_pkg::CFG_BODY: body_code_next = cfg_data_i;
                default: ;
            endcase
        end
    end

    // counters
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] scan_row_reg, scan_row_next;

    always_comb begin
        clr_cnt_next  = cmd_i.clear_en ? clr_cnt_reg + AW'(1) : clr_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        scan_row_next = scan_row_reg;
        if (cmd_i.scan_start) begin
            col_cnt_next = '0;
        end else if (cmd_i.issue) begin
            col_cnt_next = col_cnt_reg + CW'(1);
        end
        if (cmd_i.row_advance) begin
            scan_row_next = (int'(scan_row_reg) == PANEL_ROWS - 1) ? '0
                                                                   : scan_row_reg + RW'(1);
        end
    end

    // scan row split into half select and panel row address
    logic          bottom;
    logic [RW-1:0] row_mod;

    always_comb begin
        bottom = (int'(scan_row_reg) >= HALF);
        if (int'(scan_row_reg) >= 2 * HALF) begin
            row_mod = RW'(int'(scan_row_reg) - 2 * HALF);
        end else if (int'(scan_row_reg) >= HALF) begin
            row_mod = RW'(int'(scan_row_reg) - HALF);
        end else begin
            row_mod = scan_row_reg;
        end
    end

    // frame store ports
    logic                        cell_in_range;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [lmrs_pkg::CODE_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [lmrs_pkg::CODE_W-1:0] ram_rdata;

    assign cell_in_range = (int'(cell_row_i) < PANEL_ROWS) && (int'(cell_col_i) < PANEL_COLUMNS);
    assign ram_we        = cmd_i.clear_en || (cmd_i.cell_write && cell_in_range);
    assign ram_waddr     = cmd_i.clear_en ? clr_cnt_reg
                         : AW'(int'(cell_row_i) * PANEL_COLUMNS + int'(cell_col_i));
    assign ram_wdata     = cmd_i.clear_en ? '0 : cell_code_i;
    assign ram_raddr     = AW'(int'(scan_row_reg) * PANEL_COLUMNS + int'(col_cnt_reg));

    lmrs_ram #(
        .WIDTH (lmrs_pkg::CODE_W),
        .DEPTH (CELLS)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd_i.issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read stage and output register
    logic          rd_v_reg, rd_v_next;
    logic [CW-1:0] rd_col_reg, rd_col_next;
    logic          rd_last_reg, rd_last_next;
    logic          out_v_reg, out_v_next;
    logic          out_load;

    logic [lmrs_pkg::COL_OUT_W-1:0]  out_col_reg, out_col_next;
    logic [lmrs_pkg::RGB_W-1:0]      out_top_reg, out_top_next;
    logic [lmrs_pkg::RGB_W-1:0]      out_bot_reg, out_bot_next;
    logic [lmrs_pkg::ADDR_OUT_W-1:0] out_addr_reg, out_addr_next;
    logic                            out_last_reg, out_last_next;
    logic [lmrs_pkg::RGB_W-1:0]      rgb;

    assign out_load = rd_v_reg && (!out_v_reg || m_ready_i);
    assign rgb      = lmrs_pkg::code_to_rgb(ram_rdata, wall_code_reg, beak_code_reg,
                                            body_code_reg);

    always_comb begin
        rd_v_next     = rd_v_reg;
        rd_col_next   = rd_col_reg;
        rd_last_next  = rd_last_reg;
        out_v_next    = out_v_reg;
        out_col_next  = out_col_reg;
        out_top_next  = out_top_reg;
        out_bot_next  = out_bot_reg;
        out_addr_next = out_addr_reg;
        out_last_next = out_last_reg;
        if (cmd_i.issue) begin
            rd_v_next    = 1'b1;
            rd_col_next  = col_cnt_reg;
            rd_last_next = sts_o.col_last;
        end else if (out_load) begin
            rd_v_next = 1'b0;
        end
        if (out_load) begin
            out_v_next    = 1'b1;
            out_col_next  = lmrs_pkg::COL_OUT_W'(rd_col_reg);
            out_top_next  = bottom ? lmrs_pkg::RGB_BLACK : rgb;
            out_bot_next  = bottom ? rgb : lmrs_pkg::RGB_BLACK;
            out_addr_next = lmrs_pkg::ADDR_OUT_W'(row_mod);
            out_last_next = rd_last_reg;
        end else if (m_ready_i) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_code_reg <= lmrs_pkg::WALL_CODE_RST;
            beak_code_reg <= lmrs_pkg::BEAK_CODE_RST;
            body_code_reg <= lmrs_pkg::BODY_CODE_RST;
            clr_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            scan_row_reg  <= '0;
            rd_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
        end else begin
            wall_code_reg <= wall_code_next;
            beak_code_reg <= beak_code_next;
            body_code_reg <= body_code_next;
            clr_cnt_reg   <= clr_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            scan_row_reg  <= scan_row_next;
            rd_v_reg      <= rd_v_next;
            out_v_reg     <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_col_reg   <= rd_col_next;
        rd_last_reg  <= rd_last_next;
        out_col_reg  <= out_col_next;
        out_top_reg  <= out_top_next;
        out_bot_reg  <= out_bot_next;
        out_addr_reg <= out_addr_next;
        out_last_reg <= out_last_next;
    end

    assign sts_o.clear_last = (int'(clr_cnt_reg) == CELLS - 1);
    assign sts_o.col_last   = (int'(col_cnt_reg) == PANEL_COLUMNS - 1);
    assign sts_o.issue_ok   = !rd_v_reg || out_load;
    assign sts_o.pipe_empty = !rd_v_reg && !out_v_reg;

    assign m_valid_o       = out_v_reg;
    assign m_column_o      = out_col_reg;
    assign m_top_rgb_o     = out_top_reg;
    assign m_bottom_rgb_o  = out_bot_reg;
    assign m_row_address_o = out_addr_reg;
    assign m_latch_last_o  = out_last_reg;

    `LMRS_ASSERT_IMP(a_issue_no_overwrite, cmd_i.issue, !rd_v_reg || out_load,
        "read issued over an unconsumed read")
    `LMRS_ASSERT_IMP(a_clear_exclusive, cmd_i.clear_en,
        !cmd_i.issue && !cmd_i.cell_write && !cmd_i.scan_start,
        "frame store access during clear sweep")
    `LMRS_ASSERT_IMP(a_advance_when_empty, cmd_i.row_advance, !rd_v_reg && !out_v_reg,
        "scan row advanced with results still in flight")
    `LMRS_ASSERT_NXT(a_read_stage_holds, rd_v_reg && !out_load,
        rd_v_reg && $stable(rd_col_reg) && $stable(ram_rdata),
        "stalled read stage lost its data")

endmodule

`default_nettype wire

### src/led_matrix_row_scanner_top.sv
// led matrix row scanner top: a scan item gives PANEL_COLUMNS results in all, one result
// per cycle while m_ready is high (the single frame store read port sets one column per
// cycle), and the next item is taken only once every result of the scan has been taken
// reset: synchronous active-low aresetn, then a clear sweep writes zero to all
// PANEL_ROWS * PANEL_COLUMNS cells (2048 by default) before the first item; config
// writes are taken throughout
`default_nettype none

module led_matrix_row_scanner_top #(
    parameter int PANEL_COLUMNS = lmrs_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = lmrs_pkg::PANEL_ROWS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic                              s_action,
    input  wire logic [lmrs_pkg::ROW_IN_W-1:0]     s_cell_row,
    input  wire logic [lmrs_pkg::COL_IN_W-1:0]     s_cell_col,
    input  wire logic [lmrs_pkg::CODE_W-1:0]       s_cell_code,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic [lmrs_pkg::COL_OUT_W-1:0]    m_column,
    output      logic [lmrs_pkg::RGB_W-1:0]        m_top_rgb,
    output      logic [lmrs_pkg::RGB_W-1:0]        m_bottom_rgb,
    output      logic [lmrs_pkg::ADDR_OUT_W-1:0]   m_row_address,
    output      logic                              m_latch_last,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [lmrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lmrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lmrs_pkg::lmrs_cmd_t cmd;
    lmrs_pkg::lmrs_sts_t sts;

    assign cfg_ready = 1'b1;

    lmrs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid_i  (s_valid),
        .s_action_i (s_action),
        .s_ready_o  (s_ready),
        .sts_i      (sts),
        .cmd_o      (cmd)
    );

    lmrs_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_ROWS    (PANEL_ROWS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_i           (cmd),
        .sts_o           (sts),
        .cell_row_i      (s_cell_row),
        .cell_col_i      (s_cell_col),
        .cell_code_i     (s_cell_code),
        .cfg_we_i        (cfg_valid && cfg_ready),
        .cfg_index_i     (cfg_index),
        .cfg_data_i      (cfg_data),
        .m_ready_i       (m_ready),
        .m_valid_o       (m_valid),
        .m_column_o      (m_column),
        .m_top_rgb_o     (m_top_rgb),
        .m_bottom_rgb_o  (m_bottom_rgb),
        .m_row_address_o (m_row_address),
        .m_latch_last_o  (m_latch_last)
    );

endmodule

`default_nettype wire
